// ===== rtl/core/cmcs_pkg.sv =====
// Shared types and codes for the conflict-marking choice stack.
// No dependencies; imported by the channel interfaces and the top-level module.
package cmcs_pkg;

  // Fixed payload widths of the request and result channels
  localparam int REQ_W    = 2;
  localparam int OPT_IN_W = 5;
  localparam int SLOT_IN_W = 3;
  localparam int EDGE_IN_W = 16;
  localparam int CNT_IN_W = 4;
  localparam int STAT_W   = 3;
  localparam int MARK_O_W = 11;
  localparam int UNDO_O_W = 6;

  // Configuration port
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int OPTCNT_W = 6;
  localparam logic REG_OPTION_COUNT = 1'b0;

  // Request types
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SELECT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNDO   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNAVAIL   = 3'd2;
  localparam logic [STAT_W-1:0] ST_CAPACITY  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_UNDO   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_PUSH,
    S_LOAD_RD,
    S_LOAD_WR,
    S_WALK,
    S_CMP,
    S_UNDO_RD,
    S_RESP
  } state_t;

endpackage

// ===== rtl/core/cmcs_in_if.sv =====
// Request channel of the conflict-marking choice stack.
// Depends on cmcs_pkg for the payload widths.
interface cmcs_in_if import cmcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [OPT_IN_W-1:0]  option_index;
  logic [SLOT_IN_W-1:0] slot_index;
  logic [EDGE_IN_W-1:0] edge_id;
  logic [CNT_IN_W-1:0]  edge_count;

  modport source (output valid, req_type, option_index, slot_index, edge_id, edge_count,
                  input ready);
  modport sink (input valid, req_type, option_index, slot_index, edge_id, edge_count,
                output ready);
endinterface

// ===== rtl/core/cmcs_out_if.sv =====
// Result channel of the conflict-marking choice stack.
// Depends on cmcs_pkg for the payload widths.
interface cmcs_out_if import cmcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [MARK_O_W-1:0] mark_count;
  logic [UNDO_O_W-1:0] undo_depth;

  modport source (output valid, status, mark_count, undo_depth, input ready);
  modport sink (input valid, status, mark_count, undo_depth, output ready);
endinterface

// ===== rtl/core/cmcs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module cmcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/conflict_marking_choice_stack.sv =====
// Top level of the conflict-marking choice stack.
// Depends on cmcs_pkg, cmcs_in_if, cmcs_out_if and cmcs_ram.
//
// Usage: requests arrive on in_ch (valid/ready); each gives exactly one result
// on out_ch carrying status, mark count and undo depth. option_count is set
// through the APB port at byte address 0, by the user only while the block is idle;
// the block itself does not enforce this. A request is taken only in the idle state;
// its result is placed in an output register, so the next request is taken while
// that result waits. A select scans the mark store, one mark-store read a cycle during
// the availability scan, loads the chosen option's edges with edge-table reads, then
// reads each edge slot in use from the edge table and compares it against all chosen
// edges at once, stepping on through the options in use. An undo reads back the saved
// mark count and pops the undo stack. The single edge-table read port bounds the
// speed of a select.
// Reset clears the option lengths, mark count, undo depth and option_count;
// the edge table, mark store and saved counts are left as they are.
// When the receiver stalls, the result holds and one more request may be
// taken and worked; its result waits until the output register frees.
module conflict_marking_choice_stack import cmcs_pkg::*; #(
  parameter int MAX_OPTIONS = 32,
  parameter int MAX_EDGES   = 8,
  parameter int MARK_DEPTH  = 1024,
  parameter int UNDO_DEPTH  = 32,
  parameter int EDGE_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  cmcs_in_if.sink            in_ch,
  cmcs_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  localparam int OPT_W    = $clog2(MAX_OPTIONS);
  localparam int CNT_W    = $clog2(MAX_OPTIONS + 1);
  localparam int LEN_W    = $clog2(MAX_EDGES + 1);
  localparam int SLOT_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET_DEPTH = MAX_OPTIONS * MAX_EDGES;
  localparam int ET_AW    = $clog2(ET_DEPTH);
  localparam int MA_W     = $clog2(MARK_DEPTH);
  localparam int MC_W     = $clog2(MARK_DEPTH + 1);
  localparam int UA_W     = $clog2(UNDO_DEPTH);
  localparam int UC_W     = $clog2(UNDO_DEPTH + 1);

  state_t state_r, state_nxt;

  // Captured request
  logic [REQ_W-1:0]     req_r;
  logic [OPT_IN_W-1:0]  opt_r;
  logic [SLOT_IN_W-1:0] slot_r;
  logic [EDGE_IN_W-1:0] edge_r;
  logic [CNT_IN_W-1:0]  cnt_r;

  // Control state
  logic [OPTCNT_W-1:0] option_count_r;
  logic [LEN_W-1:0]    len_r [MAX_OPTIONS];
  logic [MC_W-1:0]     mark_top_r, mark_top_nxt;
  logic [UC_W-1:0]     undo_top_r, undo_top_nxt;
  logic [MC_W-1:0]     base_r, base_nxt;
  logic [MC_W-1:0]     scan_i_r, scan_i_nxt;
  logic                pend_r, pend_nxt;
  logic [CNT_W-1:0]    t1_r, t1_nxt;
  logic [LEN_W-1:0]    t2_r, t2_nxt;
  logic [LEN_W-1:0]    len_c_r, len_c_nxt;
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic [EDGE_BITS-1:0] chosen_r [MAX_EDGES];

  // Output register
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [MARK_O_W-1:0] out_mark_r;
  logic [UNDO_O_W-1:0] out_undo_r;

  // Combinational helpers
  logic              in_acc;
  logic              cfg_wr;
  logic              out_load;
  logic [CNT_W-1:0]  used;
  logic [OPT_W-1:0]  opt_idx;
  logic [OPT_W-1:0]  len_idx;
  logic [LEN_W-1:0]  len_rd;
  logic              len_we;
  logic              chosen_we;
  logic              hit;

  // Memory ports
  logic                 et_we, et_re;
  logic [ET_AW-1:0]     et_waddr, et_raddr;
  logic [EDGE_BITS-1:0] et_rdata;
  logic                 mk_we, mk_re;
  logic [MA_W-1:0]      mk_waddr, mk_raddr;
  logic [OPT_W-1:0]     mk_rdata;
  logic                 sv_we, sv_re;
  logic [UA_W-1:0]      sv_waddr, sv_raddr;
  logic [MC_W-1:0]      sv_rdata;

  cmcs_ram #(.WIDTH(EDGE_BITS), .DEPTH(ET_DEPTH)) u_edge_ram (
    .clk(clk), .we(et_we), .waddr(et_waddr), .wdata(EDGE_BITS'(edge_r)),
    .re(et_re), .raddr(et_raddr), .rdata(et_rdata)
  );

  cmcs_ram #(.WIDTH(OPT_W), .DEPTH(MARK_DEPTH)) u_mark_ram (
    .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(OPT_W'(t1_r)),
    .re(mk_re), .raddr(mk_raddr), .rdata(mk_rdata)
  );

  cmcs_ram #(.WIDTH(MC_W), .DEPTH(UNDO_DEPTH)) u_saved_ram (
    .clk(clk), .we(sv_we), .waddr(sv_waddr), .wdata(mark_top_r),
    .re(sv_re), .raddr(sv_raddr), .rdata(sv_rdata)
  );

  // Handshakes and configuration read
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_OPTION_COUNT);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_OPTION_COUNT) ? PDATA_W'(option_count_r) : '0;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.mark_count = out_mark_r;
  assign out_ch.undo_depth = out_undo_r;

  // Options in use, clipped to the table size
  assign used = (32'(option_count_r) > MAX_OPTIONS) ? CNT_W'(MAX_OPTIONS)
                                                    : CNT_W'(option_count_r);
  assign opt_idx = OPT_W'(opt_r);
  assign len_idx = (state_r == S_PUSH) ? opt_idx : OPT_W'(t1_r);
  assign len_rd  = len_r[len_idx];

  // Compare the fetched edge against every loaded edge of the chosen option
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < MAX_EDGES; k++) begin
      if ((LEN_W'(k) < len_c_r) && (chosen_r[k] == et_rdata)) begin
        hit = 1'b1;
      end
    end
  end

  // Next state, counters and memory controls
  always_comb begin
    state_nxt    = state_r;
    mark_top_nxt = mark_top_r;
    undo_top_nxt = undo_top_r;
    base_nxt     = base_r;
    scan_i_nxt   = scan_i_r;
    pend_nxt     = pend_r;
    t1_nxt       = t1_r;
    t2_nxt       = t2_r;
    len_c_nxt    = len_c_r;
    status_nxt   = status_r;
    out_load     = 1'b0;
    len_we       = 1'b0;
    chosen_we    = 1'b0;
    et_we        = 1'b0;
    et_waddr     = ET_AW'(32'(opt_r) * MAX_EDGES + 32'(slot_r));
    et_re        = 1'b0;
    et_raddr     = ET_AW'(32'(opt_r) * MAX_EDGES + 32'(t2_r));
    mk_we        = 1'b0;
    mk_waddr     = MA_W'(mark_top_r);
    mk_re        = 1'b0;
    mk_raddr     = MA_W'(scan_i_r);
    sv_we        = 1'b0;
    sv_waddr     = UA_W'(undo_top_r);
    sv_re        = 1'b0;
    sv_raddr     = UA_W'(undo_top_r - 1'b1);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        status_nxt = ST_DONE;
        state_nxt  = S_RESP;
        priority case (req_r)
          REQ_WRITE: begin
            if (32'(opt_r) >= MAX_OPTIONS) begin
              status_nxt = ST_RANGE;
            end else begin
              len_we = 1'b1;
              et_we  = (32'(slot_r) < MAX_EDGES);
            end
          end
          REQ_SELECT: begin
            if (32'(opt_r) >= 32'(used)) begin
              status_nxt = ST_RANGE;
            end else begin
              scan_i_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = S_SCAN;
            end
          end
          REQ_UNDO: begin
            if (undo_top_r == '0) begin
              status_nxt = ST_NO_UNDO;
            end else begin
              sv_re     = 1'b1;
              state_nxt = S_UNDO_RD;
            end
          end
          default: begin
            status_nxt = ST_DONE;
          end
        endcase
      end

      // Scan the mark store one entry a cycle for the chosen option
      S_SCAN: begin
        if (pend_r && (mk_rdata == opt_idx)) begin
          status_nxt = ST_UNAVAIL;
          state_nxt  = S_RESP;
        end else if (scan_i_r < mark_top_r) begin
          mk_re      = 1'b1;
          scan_i_nxt = scan_i_r + 1'b1;
          pend_nxt   = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = S_PUSH;
        end
      end

      // Save the mark count and latch the chosen option's length; report capacity when the undo stack is full
      S_PUSH: begin
        if (32'(undo_top_r) >= UNDO_DEPTH) begin
          status_nxt = ST_CAPACITY;
          state_nxt  = S_RESP;
        end else begin
          sv_we        = 1'b1;
          undo_top_nxt = undo_top_r + 1'b1;
          base_nxt     = mark_top_r;
          len_c_nxt    = len_rd;
          t2_nxt       = '0;
          state_nxt    = S_LOAD_RD;
        end
      end

      S_LOAD_RD: begin
        if (t2_r < len_c_r) begin
          et_re     = 1'b1;
          state_nxt = S_LOAD_WR;
        end else begin
          t1_nxt    = '0;
          t2_nxt    = '0;
          state_nxt = S_WALK;
        end
      end

      S_LOAD_WR: begin
        chosen_we = 1'b1;
        t2_nxt    = t2_r + 1'b1;
        state_nxt = S_LOAD_RD;
      end

      // Walk every used slot of every option in use
      S_WALK: begin
        et_raddr = ET_AW'(32'(t1_r) * MAX_EDGES + 32'(t2_r));
        if (t1_r >= used) begin
          status_nxt = ST_DONE;
          state_nxt  = S_RESP;
        end else if (t2_r >= len_rd) begin
          t1_nxt = t1_r + 1'b1;
          t2_nxt = '0;
        end else begin
          et_re     = 1'b1;
          state_nxt = S_CMP;
        end
      end

      // Append a mark on a shared edge; roll back when the store is full
      S_CMP: begin
        state_nxt = S_WALK;
        t2_nxt    = t2_r + 1'b1;
        if (hit) begin
          if (32'(mark_top_r) >= MARK_DEPTH) begin
            undo_top_nxt = undo_top_r - 1'b1;
            mark_top_nxt = base_r;
            status_nxt   = ST_CAPACITY;
            state_nxt    = S_RESP;
          end else begin
            mk_we        = 1'b1;
            mark_top_nxt = mark_top_r + 1'b1;
          end
        end
      end

      S_UNDO_RD: begin
        undo_top_nxt = undo_top_r - 1'b1;
        if (sv_rdata < mark_top_r) begin
          mark_top_nxt = sv_rdata;
        end
        status_nxt = ST_DONE;
        state_nxt  = S_RESP;
      end

      // Hold the result until the output register is free
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      mark_top_r     <= '0;
      undo_top_r     <= '0;
      option_count_r <= '0;
      out_valid_r    <= 1'b0;
      pend_r         <= 1'b0;
      for (int i = 0; i < MAX_OPTIONS; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      mark_top_r <= mark_top_nxt;
      undo_top_r <= undo_top_nxt;
      pend_r     <= pend_nxt;
      if (cfg_wr) begin
        option_count_r <= cfg_pwdata[OPTCNT_W-1:0];
      end
      if (len_we) begin
        len_r[opt_idx] <= (32'(cnt_r) > MAX_EDGES) ? LEN_W'(MAX_EDGES) : LEN_W'(cnt_r);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    scan_i_r <= scan_i_nxt;
    t1_r     <= t1_nxt;
    t2_r     <= t2_nxt;
    len_c_r  <= len_c_nxt;
    status_r <= status_nxt;
    if (in_acc) begin
      req_r  <= in_ch.req_type;
      opt_r  <= in_ch.option_index;
      slot_r <= in_ch.slot_index;
      edge_r <= in_ch.edge_id;
      cnt_r  <= in_ch.edge_count;
    end
    if (chosen_we) begin
      chosen_r[t2_r[SLOT_W-1:0]] <= et_rdata;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_mark_r   <= MARK_O_W'(mark_top_r);
      out_undo_r   <= UNDO_O_W'(undo_top_r);
    end
  end

`ifndef ASSERT_OFF
  a_mark_room: assert property (@(posedge clk) disable iff (!rst_n)
    mk_we |-> (32'(mark_top_r) < MARK_DEPTH))
    else $error("mark store written beyond its depth");

  a_undo_room: assert property (@(posedge clk) disable iff (!rst_n)
    sv_we |-> (32'(undo_top_r) < UNDO_DEPTH))
    else $error("undo stack pushed beyond its depth");

  a_mark_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(mk_we && mk_re))
    else $error("mark store read and written in one cycle");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_DISPATCH))
    else $error("accepted request not dispatched");

  a_undo_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNDO_RD) |-> (undo_top_r != '0))
    else $error("undo popped an empty stack");
`endif

endmodule
